@@ sv/vec3_arithmetic_unit_top_macros.svh @@
// assertion macros for the vec3 arithmetic unit
`ifndef VEC3_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define VEC3_ARITHMETIC_UNIT_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define V3AU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define V3AU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/v3au_pkg.sv @@
// shared constants, types and helper functions of the vec3 arithmetic unit
package v3au_pkg;

	localparam int COMP_WIDTH  = 16;
	localparam int FRAC_BITS   = 8;
	localparam int PROD_W      = 2 * COMP_WIDTH;
	localparam int WIDE_W      = PROD_W + 2;
	localparam int DIVN_W      = COMP_WIDTH + FRAC_BITS;
	localparam int S2_W        = 2 * COMP_WIDTH;
	localparam int QB          = FRAC_BITS + 2;
	localparam int NW          = 2 * QB + S2_W + 2;
	localparam int ITER_STAGES = (DIVN_W + 1) / 2;

	localparam logic [2:0] FN_ADD   = 3'd0;
	localparam logic [2:0] FN_SUB   = 3'd1;
	localparam logic [2:0] FN_SCALE = 3'd2;
	localparam logic [2:0] FN_DIV   = 3'd3;
	localparam logic [2:0] FN_CROSS = 3'd4;
	localparam logic [2:0] FN_NORM  = 3'd5;

	typedef logic signed [COMP_WIDTH-1:0] comp_t;
	typedef logic [COMP_WIDTH-1:0] mag_t;

	typedef struct packed {
		logic                        vld;
		logic [2:0]                  func;
		logic                        err;
		logic [2:0][COMP_WIDTH-1:0]  res;
		logic [2:0]                  neg;
		logic [2:0][DIVN_W-1:0]      dnum;
		logic [2:0][COMP_WIDTH-1:0]  drem;
		logic [2:0][DIVN_W-1:0]      dquo;
		logic [COMP_WIDTH-1:0]       dden;
		logic [S2_W-1:0]             s2;
		logic [2:0][NW-1:0]          nr;
		logic [2:0][NW-1:0]          np;
		logic [2:0][NW-1:0]          nq;
		logic [2:0][QB-1:0]          nqt;
	} iter_t;

	function automatic mag_t mag_of(input comp_t v);
		comp_t n;
		n = -v;
		return v[COMP_WIDTH-1] ? mag_t'(n) : mag_t'(v);
	endfunction

	// drop the fraction bits of a product, rounding toward zero
	function automatic logic signed [PROD_W-1:0] tz_frac(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p;
		if (p[PROD_W-1])
			t = p + PROD_W'((1 << FRAC_BITS) - 1);
		return t >>> FRAC_BITS;
	endfunction

	function automatic comp_t sat_comp(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'((64'd1 << (COMP_WIDTH - 1)) - 64'd1);
		lo = -hi - 1;
		if (v > hi)
			return comp_t'(hi[COMP_WIDTH-1:0]);
		if (v < lo)
			return comp_t'(lo[COMP_WIDTH-1:0]);
		return comp_t'(v[COMP_WIDTH-1:0]);
	endfunction

	// sign and magnitude to a saturated component
	function automatic comp_t sat_mag(input logic neg, input logic [DIVN_W-1:0] q);
		logic [DIVN_W-1:0] lim;
		logic [COMP_WIDTH-1:0] m;
		lim = DIVN_W'(64'd1 << (COMP_WIDTH - 1));
		m = q[COMP_WIDTH-1:0];
		if (neg) begin
			if (q >= lim)
				return comp_t'({1'b1, {(COMP_WIDTH-1){1'b0}}});
			return -$signed(m);
		end
		if (q >= lim)
			return comp_t'({1'b0, {(COMP_WIDTH-1){1'b1}}});
		return $signed(m);
	endfunction

endpackage

@@ sv/v3au_in_if.sv @@
// input channel: operation, two vectors and a scalar
interface v3au_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        func;
	v3au_pkg::comp_t   ax;
	v3au_pkg::comp_t   ay;
	v3au_pkg::comp_t   az;
	v3au_pkg::comp_t   bx;
	v3au_pkg::comp_t   by;
	v3au_pkg::comp_t   bz;
	v3au_pkg::comp_t   scalar;

	modport source(output valid, func, ax, ay, az, bx, by, bz, scalar, input ready);
	modport sink(input valid, func, ax, ay, az, bx, by, bz, scalar, output ready);
endinterface

@@ sv/v3au_out_if.sv @@
// output channel: result vector and error flag
interface v3au_out_if;
	logic              valid;
	logic              ready;
	v3au_pkg::comp_t   rx;
	v3au_pkg::comp_t   ry;
	v3au_pkg::comp_t   rz;
	logic              err;

	modport source(output valid, rx, ry, rz, err, input ready);
	modport sink(input valid, rx, ry, rz, err, output ready);
endinterface

@@ sv/v3au_iter.sv @@
// iterative section: two divider bits per stage and one normalise root bit per stage while root bits remain
module v3au_iter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  v3au_pkg::iter_t   din,
	output v3au_pkg::iter_t   dout
);

	v3au_pkg::iter_t stg_s [v3au_pkg::ITER_STAGES];

	for (genvar j = 0; j < v3au_pkg::ITER_STAGES; j++) begin : g_stage
		localparam int DB0 = v3au_pkg::DIVN_W - 1 - 2 * j;
		localparam int NB  = v3au_pkg::QB - 1 - j;
		localparam int NBS = (NB >= 0) ? NB : 0;

		v3au_pkg::iter_t cur;
		v3au_pkg::iter_t nx;

		if (j == 0) begin : g_first
			assign cur = din;
		end else begin : g_next
			assign cur = stg_s[j-1];
		end

		always_comb begin
			logic [v3au_pkg::COMP_WIDTH:0] rem;
			logic [v3au_pkg::NW-1:0] cand;
			logic [v3au_pkg::NW-1:0] s2w;
			int db;
			nx = cur;
			s2w = v3au_pkg::NW'(cur.s2);
			for (int l = 0; l < 3; l++) begin
				// restoring division, two quotient bits
				for (int u = 0; u < 2; u++) begin
					db = DB0 - u;
					if (db >= 0) begin
						rem = {nx.drem[l], nx.dnum[l][db]};
						if (rem >= {1'b0, nx.dden}) begin
							rem = rem - {1'b0, nx.dden};
							nx.dquo[l][db] = 1'b1;
						end
						nx.drem[l] = rem[v3au_pkg::COMP_WIDTH-1:0];
					end
				end
				// root bit: keep it when (q+2^b)^2 * s2 stays within a^2 * 2^2f
				if (NB >= 0) begin
					cand = nx.np[l] + (nx.nq[l] << (NBS + 1)) + (s2w << (2 * NBS));
					if (cand <= nx.nr[l]) begin
						nx.np[l] = cand;
						nx.nq[l] = nx.nq[l] + (s2w << NBS);
						nx.nqt[l][NBS] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_s[j].vld <= 1'b0;
			end else if (adv) begin
				stg_s[j] <= nx;
			end
		end
	end

	assign dout = stg_s[v3au_pkg::ITER_STAGES-1];

endmodule

@@ sv/vec3_arithmetic_unit_top.sv @@
// vec3 arithmetic unit top level: pipelined add, sub, scale, divide, cross, normalise
//
//  channel | dir | payload                               | handshake
//  req     | in  | func, ax ay az, bx by bz, scalar      | valid / ready
//  rsp     | out | rx ry rz, err                         | valid / ready
//
// one word accepted per cycle while rsp is not stalled; every word passes through
// products, setup, 12 divider/root stages and the output register, the stage
// count set by the 24 quotient bits of the divider at two bits a stage
// arst_n clears only the valid bits; payload registers are not reset
// a stall on rsp freezes the whole pipe at once, so nothing is lost or repeated
`include "vec3_arithmetic_unit_top_macros.svh"

module vec3_arithmetic_unit_top (
	input  logic      clk,
	input  logic      arst_n,
	v3au_in_if.sink   req,
	v3au_out_if.source rsp
);

	localparam v3au_pkg::comp_t UNIT = v3au_pkg::comp_t'(1 << v3au_pkg::FRAC_BITS);

	// whole pipe moves when the output register is empty or being drained
	logic adv;

	// stage 1: operands and all products
	logic                                vld_s1;
	logic [2:0]                          func_s1;
	v3au_pkg::comp_t                     a_s1 [3];
	v3au_pkg::comp_t                     b_s1 [3];
	v3au_pkg::comp_t                     s_s1;
	logic signed [v3au_pkg::PROD_W-1:0]  sp_s1 [3];
	logic signed [v3au_pkg::PROD_W-1:0]  cp_s1 [6];
	logic [v3au_pkg::S2_W-1:0]           sq_s1 [3];

	v3au_pkg::comp_t                     ain [3];
	v3au_pkg::comp_t                     bin [3];
	v3au_pkg::mag_t                      amag [3];

	// stage 2: simple results finished, divider and root set up
	v3au_pkg::iter_t                     set_nx;
	v3au_pkg::iter_t                     set_s2;
	v3au_pkg::iter_t                     itr_out;

	// output register
	logic                                out_vld_s15;
	logic [2:0]                          func_s15;
	v3au_pkg::comp_t                     rx_s15;
	v3au_pkg::comp_t                     ry_s15;
	v3au_pkg::comp_t                     rz_s15;
	logic                                err_s15;
	v3au_pkg::comp_t                     r_nx [3];

	assign adv       = !out_vld_s15 || rsp.ready;
	assign req.ready = adv;

	assign ain[0] = req.ax;
	assign ain[1] = req.ay;
	assign ain[2] = req.az;
	assign bin[0] = req.bx;
	assign bin[1] = req.by;
	assign bin[2] = req.bz;

	always_comb begin
		for (int i = 0; i < 3; i++)
			amag[i] = v3au_pkg::mag_of(ain[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= req.func;
			s_s1    <= req.scalar;
			for (int i = 0; i < 3; i++) begin
				a_s1[i]  <= ain[i];
				b_s1[i]  <= bin[i];
				sp_s1[i] <= v3au_pkg::PROD_W'(ain[i]) * v3au_pkg::PROD_W'(req.scalar);
				sq_s1[i] <= v3au_pkg::S2_W'(amag[i]) * v3au_pkg::S2_W'(amag[i]);
			end
			// cross product terms, paired as minuend / subtrahend per lane
			cp_s1[0] <= v3au_pkg::PROD_W'(ain[1]) * v3au_pkg::PROD_W'(bin[2]);
			cp_s1[1] <= v3au_pkg::PROD_W'(ain[2]) * v3au_pkg::PROD_W'(bin[1]);
			cp_s1[2] <= v3au_pkg::PROD_W'(ain[2]) * v3au_pkg::PROD_W'(bin[0]);
			cp_s1[3] <= v3au_pkg::PROD_W'(ain[0]) * v3au_pkg::PROD_W'(bin[2]);
			cp_s1[4] <= v3au_pkg::PROD_W'(ain[0]) * v3au_pkg::PROD_W'(bin[1]);
			cp_s1[5] <= v3au_pkg::PROD_W'(ain[1]) * v3au_pkg::PROD_W'(bin[0]);
		end
	end

	// stage 2 set-up
	always_comb begin
		logic signed [v3au_pkg::WIDE_W-1:0] w;
		logic signed [v3au_pkg::WIDE_W-1:0] wb;
		logic signed [v3au_pkg::PROD_W-1:0] t1;
		logic signed [v3au_pkg::PROD_W-1:0] t2;
		logic [v3au_pkg::S2_W-1:0] s2;
		s2 = sq_s1[0] + sq_s1[1] + sq_s1[2];
		set_nx      = '0;
		set_nx.vld  = vld_s1;
		set_nx.func = func_s1;
		set_nx.s2   = s2;
		set_nx.dden = v3au_pkg::mag_of(s_s1);
		for (int i = 0; i < 3; i++) begin
			w  = '0;
			wb = '0;
			t1 = '0;
			t2 = '0;
			case (func_s1)
				v3au_pkg::FN_ADD: begin
					w  = v3au_pkg::WIDE_W'(a_s1[i]);
					wb = v3au_pkg::WIDE_W'(b_s1[i]);
					w  = w + wb;
				end
				v3au_pkg::FN_SUB: begin
					w  = v3au_pkg::WIDE_W'(a_s1[i]);
					wb = v3au_pkg::WIDE_W'(b_s1[i]);
					w  = w - wb;
				end
				v3au_pkg::FN_SCALE: begin
					t1 = v3au_pkg::tz_frac(sp_s1[i]);
					w  = v3au_pkg::WIDE_W'(t1);
				end
				v3au_pkg::FN_CROSS: begin
					t1 = v3au_pkg::tz_frac(cp_s1[2*i]);
					t2 = v3au_pkg::tz_frac(cp_s1[2*i+1]);
					w  = v3au_pkg::WIDE_W'(t1);
					wb = v3au_pkg::WIDE_W'(t2);
					w  = w - wb;
				end
				default: begin
					w = '0;
				end
			endcase
			set_nx.res[i]  = v3au_pkg::sat_comp(w);
			set_nx.dnum[i] = {v3au_pkg::mag_of(a_s1[i]), {v3au_pkg::FRAC_BITS{1'b0}}};
			set_nx.nr[i]   = v3au_pkg::NW'(sq_s1[i]) << (2 * v3au_pkg::FRAC_BITS);
			set_nx.neg[i]  = (func_s1 == v3au_pkg::FN_DIV) ?
				(a_s1[i][v3au_pkg::COMP_WIDTH-1] ^ s_s1[v3au_pkg::COMP_WIDTH-1]) :
				a_s1[i][v3au_pkg::COMP_WIDTH-1];
		end
		// divide by zero, or normalising the zero vector
		set_nx.err = ((func_s1 == v3au_pkg::FN_DIV) && (s_s1 == '0)) ||
			((func_s1 == v3au_pkg::FN_NORM) && (s2 == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_s2.vld <= 1'b0;
		end else if (adv) begin
			set_s2 <= set_nx;
		end
	end

	v3au_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.din    (set_s2),
		.dout   (itr_out)
	);

	// final selection and saturation of quotient / root magnitudes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (itr_out.func) inside
				v3au_pkg::FN_ADD, v3au_pkg::FN_SUB, v3au_pkg::FN_SCALE,
				v3au_pkg::FN_CROSS: begin
					r_nx[i] = v3au_pkg::comp_t'(itr_out.res[i]);
				end
				v3au_pkg::FN_DIV: begin
					r_nx[i] = itr_out.err ? '0 :
						v3au_pkg::sat_mag(itr_out.neg[i], itr_out.dquo[i]);
				end
				v3au_pkg::FN_NORM: begin
					r_nx[i] = itr_out.err ? '0 :
						v3au_pkg::sat_mag(itr_out.neg[i],
							v3au_pkg::DIVN_W'(itr_out.nqt[i]));
				end
				default: begin
					r_nx[i] = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s15 <= 1'b0;
		end else if (adv) begin
			out_vld_s15 <= itr_out.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s15 <= itr_out.func;
			rx_s15   <= r_nx[0];
			ry_s15   <= r_nx[1];
			rz_s15   <= r_nx[2];
			err_s15  <= itr_out.err;
		end
	end

	assign rsp.valid = out_vld_s15;
	assign rsp.rx    = rx_s15;
	assign rsp.ry    = ry_s15;
	assign rsp.rz    = rz_s15;
	assign rsp.err   = err_s15;

	// an error word always carries the zero vector
	`V3AU_ASSERT_NOW(a_err_zero, out_vld_s15 && err_s15, rx_s15 == '0 && ry_s15 == '0 && rz_s15 == '0, "error word with non-zero vector")

	// only divide and normalise can raise the error flag
	`V3AU_ASSERT_NOW(a_err_func, out_vld_s15 && err_s15, func_s15 == v3au_pkg::FN_DIV || func_s15 == v3au_pkg::FN_NORM, "error flag on wrong operation")

	// a normalised x or z component never exceeds one in magnitude
	`V3AU_ASSERT_NOW(a_norm_unit, out_vld_s15 && func_s15 == v3au_pkg::FN_NORM, rx_s15 <= UNIT && rx_s15 >= -UNIT && rz_s15 <= UNIT && rz_s15 >= -UNIT, "normalised component above one")

	// a finished word leaving the last iterative stage lands in the output register
	`V3AU_ASSERT_NEXT(a_out_load, itr_out.vld && adv, out_vld_s15, "word lost before output register")

endmodule
